FILE: hdl/sasc_pkg.sv
`timescale 1ns / 1ps

package sasc_pkg;

    // Fixed point: 65536 = 1.0 for scales and opacity
    localparam logic signed [23:0] ONE_FIX = 24'sd65536;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_RATE     = 3'd0,
        REG_FRAME_COUNT   = 3'd1,
        REG_FRAME_WIDTH   = 3'd2,
        REG_FRAME_HEIGHT  = 3'd3,
        REG_ROTATION_STEP = 3'd4,
        REG_OPACITY_STEP  = 3'd5,
        REG_SCALE_STEP    = 3'd6
    } reg_idx_t;

    // Command codes
    typedef enum logic [3:0] {
        OP_TICK      = 4'd0,
        OP_SET_POS   = 4'd1,
        OP_TGT_POS   = 4'd2,
        OP_SET_SCALE = 4'd3,
        OP_SET_XS    = 4'd4,
        OP_SET_YS    = 4'd5,
        OP_TGT_SCALE = 4'd6,
        OP_TGT_XS    = 4'd7,
        OP_TGT_YS    = 4'd8,
        OP_SET_OPAC  = 4'd9,
        OP_TGT_OPAC  = 4'd10,
        OP_SET_ROT   = 4'd11,
        OP_TGT_ROT   = 4'd12
    } opcode_t;

    typedef struct packed {
        logic [7:0]  tick_rate;
        logic [7:0]  frame_count;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [15:0] rotation_step;
        logic [15:0] opacity_step;
        logic [15:0] scale_step;
    } cfg_t;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [23:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] cur_x;
        logic signed [15:0] cur_y;
        logic signed [23:0] cur_xscale;
        logic signed [23:0] cur_yscale;
        logic signed [23:0] cur_opacity;
        logic signed [23:0] cur_rotation;
        logic [7:0]         cur_frame;
        logic [15:0]        sheet_col_offset;
        logic [19:0]        sheet_row_offset;
    } out_item_t;

endpackage

FILE: hdl/sasc_cfg.sv
`timescale 1ns / 1ps

module sasc_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_en,
    input  logic [sasc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sasc_pkg::CFG_DATA_W-1:0] cfg_data,
    output sasc_pkg::cfg_t                 cfg
);
    import sasc_pkg::*;

    cfg_t cfg_reg;

    // Register file, written by index; unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_rate     <= 8'd4;
            cfg_reg.frame_count   <= 8'd1;
            cfg_reg.frame_width   <= 12'd0;
            cfg_reg.frame_height  <= 12'd0;
            cfg_reg.rotation_step <= 16'd179;
            cfg_reg.opacity_step  <= 16'd1311;
            cfg_reg.scale_step    <= 16'd13107;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                REG_TICK_RATE:     cfg_reg.tick_rate     <= cfg_data[7:0];
                REG_FRAME_COUNT:   cfg_reg.frame_count   <= cfg_data[7:0];
                REG_FRAME_WIDTH:   cfg_reg.frame_width   <= cfg_data[11:0];
                REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= cfg_data[11:0];
                REG_ROTATION_STEP: cfg_reg.rotation_step <= cfg_data;
                REG_OPACITY_STEP:  cfg_reg.opacity_step  <= cfg_data;
                REG_SCALE_STEP:    cfg_reg.scale_step    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/sasc_slew.sv
`timescale 1ns / 1ps

// Moves a value one step toward its goal, clamping at the goal
module sasc_slew
#(
    parameter int W  = 24,
    parameter int SW = 16
)
(
    input  logic signed [W-1:0] now,
    input  logic signed [W-1:0] goal,
    input  logic [SW-1:0]       step,
    output logic signed [W-1:0] slewed
);
    logic signed [W+1:0] n_x;
    logic signed [W+1:0] g_x;
    logic signed [W+1:0] a_x;
    logic signed [W+1:0] up;
    logic signed [W+1:0] dn;

    // Two guard bits keep the sums free of overflow
    assign n_x = {{2{now[W-1]}}, now};
    assign g_x = {{2{goal[W-1]}}, goal};
    assign a_x = {{(W+2-SW){1'b0}}, step};
    assign up  = n_x + a_x;
    assign dn  = n_x - a_x;

    always_comb
    begin
        if (g_x > n_x)
            slewed = (up >= g_x) ? goal : up[W-1:0];
        else if (g_x < n_x)
            slewed = (dn <= g_x) ? goal : dn[W-1:0];
        else
            slewed = now;
    end

endmodule

FILE: hdl/sasc_frame.sv
`timescale 1ns / 1ps

// Tick divider, frame counter and sheet cell position.
// Column and row follow the frame by increments, so no divider is needed.
module sasc_frame
#(
    parameter int FRAMES_PER_ROW = 10
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tick,
    input  sasc_pkg::cfg_t cfg,
    output logic [7:0]     frame,
    output logic [15:0]    col_offset,
    output logic [19:0]    row_offset
);
    import sasc_pkg::*;

    localparam int CW    = (FRAMES_PER_ROW > 1) ? $clog2(FRAMES_PER_ROW) : 1;
    localparam int CPW   = 12 + CW;
    localparam logic [CW-1:0] COL_LAST = CW'(FRAMES_PER_ROW - 1);

    logic [7:0]    div_reg,   div_next;
    logic [7:0]    frame_reg, frame_next;
    logic [CW-1:0] col_reg,   col_next;
    logic [7:0]    row_reg,   row_next;
    logic [7:0]    div_inc;
    logic [7:0]    frame_inc;
    logic [CPW-1:0] col_prod;
    logic [19:0]   row_prod;

    assign div_inc   = div_reg + 8'd1;
    assign frame_inc = frame_reg + 8'd1;

    // Next divider, frame and cell position
    always_comb
    begin
        div_next   = div_reg;
        frame_next = frame_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (tick)
        begin
            div_next = div_inc;
            if (div_inc >= cfg.tick_rate)
            begin
                div_next = 8'd0;
                if (frame_inc == cfg.frame_count || frame_inc == 8'd0)
                begin
                    frame_next = 8'd0;
                    col_next   = '0;
                    row_next   = 8'd0;
                end
                else
                begin
                    frame_next = frame_inc;
                    if (col_reg == COL_LAST)
                    begin
                        col_next = '0;
                        row_next = row_reg + 8'd1;
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg   <= 8'd0;
            frame_reg <= 8'd0;
            col_reg   <= '0;
            row_reg   <= 8'd0;
        end
        else
        begin
            div_reg   <= div_next;
            frame_reg <= frame_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // Sheet offsets of the frame after this beat
    assign col_prod   = {{CW{1'b0}}, cfg.frame_width} * {{12{1'b0}}, col_next};
    assign row_prod   = {8'd0, cfg.frame_height} * {12'd0, row_next};
    assign frame      = frame_next;
    assign col_offset = 16'(col_prod);
    assign row_offset = row_prod;

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_LAST)
        else $error("sheet column beyond row length");

    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg == 8'd0 |-> (col_reg == '0 && row_reg == 8'd0))
        else $error("cell position not cleared with frame");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick |=> ($stable(frame_reg) && $stable(div_reg)))
        else $error("frame counter moved without a tick");

endmodule

FILE: hdl/sprite_animation_slew_controller.sv
`timescale 1ns / 1ps

// Channel   Signals                              Direction  Beat
// in        in_valid, in_ready, in_data          input      one command or tick
// out       out_valid, out_ready, out_data       output     one result per input beat
// cfg       cfg_en, cfg_index, cfg_data          input      one register write
//
// One beat per cycle is sustained while out_ready is high; a result appears in the cycle after its input beat.
// All property updates and the sheet offsets are done before the single output register.
// in_ready is low only while a result is held in the output register and out_ready is low.
// Reset (rst_n, asynchronous) restores all but the output data register at once.
module sprite_animation_slew_controller
#(
    parameter int FRAMES_PER_ROW = 10
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_en,
    input  logic [sasc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sasc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sasc_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sasc_pkg::out_item_t            out_data
);
    import sasc_pkg::*;

    cfg_t cfg;
    logic in_fire;
    logic tick;

    logic signed [15:0] x_reg,   x_next,   gx_reg,   gx_next;
    logic signed [15:0] y_reg,   y_next,   gy_reg,   gy_next;
    logic signed [23:0] xs_reg,  xs_next,  gxs_reg,  gxs_next;
    logic signed [23:0] ys_reg,  ys_next,  gys_reg,  gys_next;
    logic signed [23:0] op_reg,  op_next,  gop_reg,  gop_next;
    logic signed [23:0] rot_reg, rot_next, grot_reg, grot_next;

    logic signed [15:0] x_slew, y_slew;
    logic signed [23:0] xs_slew, ys_slew, op_slew, rot_slew;

    logic [7:0]  frame;
    logic [15:0] col_offset;
    logic [19:0] row_offset;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign tick     = in_fire && (in_data.opcode == OP_TICK);

    sasc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sasc_frame #(.FRAMES_PER_ROW(FRAMES_PER_ROW)) u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .cfg        (cfg),
        .frame      (frame),
        .col_offset (col_offset),
        .row_offset (row_offset)
    );

    // Slew units, position steps by the tick rate
    sasc_slew #(.W(16), .SW(8)) u_slew_x
        (.now(x_reg), .goal(gx_reg), .step(cfg.tick_rate), .slewed(x_slew));
    sasc_slew #(.W(16), .SW(8)) u_slew_y
        (.now(y_reg), .goal(gy_reg), .step(cfg.tick_rate), .slewed(y_slew));
    sasc_slew #(.W(24), .SW(16)) u_slew_xs
        (.now(xs_reg), .goal(gxs_reg), .step(cfg.scale_step), .slewed(xs_slew));
    sasc_slew #(.W(24), .SW(16)) u_slew_ys
        (.now(ys_reg), .goal(gys_reg), .step(cfg.scale_step), .slewed(ys_slew));
    sasc_slew #(.W(24), .SW(16)) u_slew_op
        (.now(op_reg), .goal(gop_reg), .step(cfg.opacity_step), .slewed(op_slew));
    sasc_slew #(.W(24), .SW(16)) u_slew_rot
        (.now(rot_reg), .goal(grot_reg), .step(cfg.rotation_step), .slewed(rot_slew));

    // Command decode
    always_comb
    begin
        x_next    = x_reg;    gx_next   = gx_reg;
        y_next    = y_reg;    gy_next   = gy_reg;
        xs_next   = xs_reg;   gxs_next  = gxs_reg;
        ys_next   = ys_reg;   gys_next  = gys_reg;
        op_next   = op_reg;   gop_next  = gop_reg;
        rot_next  = rot_reg;  grot_next = grot_reg;
        if (in_fire)
        begin
            unique case (in_data.opcode)
                OP_TICK:
                begin
                    x_next   = x_slew;
                    y_next   = y_slew;
                    xs_next  = xs_slew;
                    ys_next  = ys_slew;
                    op_next  = op_slew;
                    rot_next = rot_slew;
                end
                OP_SET_POS:
                begin
                    x_next  = in_data.pos_x;
                    gx_next = in_data.pos_x;
                    y_next  = in_data.pos_y;
                    gy_next = in_data.pos_y;
                end
                OP_TGT_POS:
                begin
                    gx_next = in_data.pos_x;
                    gy_next = in_data.pos_y;
                end
                OP_SET_SCALE:
                begin
                    xs_next  = in_data.value;
                    gxs_next = in_data.value;
                    ys_next  = in_data.value;
                    gys_next = in_data.value;
                end
                OP_SET_XS:
                begin
                    xs_next  = in_data.value;
                    gxs_next = in_data.value;
                end
                OP_SET_YS:
                begin
                    ys_next  = in_data.value;
                    gys_next = in_data.value;
                end
                OP_TGT_SCALE:
                begin
                    gxs_next = in_data.value;
                    gys_next = in_data.value;
                end
                OP_TGT_XS:    gxs_next = in_data.value;
                OP_TGT_YS:    gys_next = in_data.value;
                OP_SET_OPAC:
                begin
                    op_next  = in_data.value;
                    gop_next = in_data.value;
                end
                OP_TGT_OPAC:  gop_next = in_data.value;
                OP_SET_ROT:
                begin
                    rot_next  = in_data.value;
                    grot_next = in_data.value;
                end
                OP_TGT_ROT:   grot_next = in_data.value;
                default: ;
            endcase
        end
    end

    // Property state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;       gx_reg   <= '0;
            y_reg    <= '0;       gy_reg   <= '0;
            xs_reg   <= ONE_FIX;  gxs_reg  <= ONE_FIX;
            ys_reg   <= ONE_FIX;  gys_reg  <= ONE_FIX;
            op_reg   <= ONE_FIX;  gop_reg  <= ONE_FIX;
            rot_reg  <= '0;       grot_reg <= '0;
        end
        else
        begin
            x_reg    <= x_next;    gx_reg   <= gx_next;
            y_reg    <= y_next;    gy_reg   <= gy_next;
            xs_reg   <= xs_next;   gxs_reg  <= gxs_next;
            ys_reg   <= ys_next;   gys_reg  <= gys_next;
            op_reg   <= op_next;   gop_reg  <= gop_next;
            rot_reg  <= rot_next;  grot_reg <= grot_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg.cur_x            <= x_next;
            out_data_reg.cur_y            <= y_next;
            out_data_reg.cur_xscale       <= xs_next;
            out_data_reg.cur_yscale       <= ys_next;
            out_data_reg.cur_opacity      <= op_next;
            out_data_reg.cur_rotation     <= rot_next;
            out_data_reg.cur_frame        <= frame;
            out_data_reg.sheet_col_offset <= col_offset;
            out_data_reg.sheet_row_offset <= row_offset;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_set_pos: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.opcode == OP_SET_POS |=>
            (out_data.cur_x == $past(in_data.pos_x) && out_data.cur_y == $past(in_data.pos_y)))
        else $error("set position not reflected in result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> (out_valid && $stable(out_data)))
        else $error("result dropped or changed while stalled");

endmodule
